[hdl/snp_pkg.sv]
// Package with the shared types, constants and frame helper of the sensor node poller.
package snp_pkg;

  localparam int unsigned NODE_COUNT = 14;
  localparam int unsigned NODE_IDX_W = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BYTE_CNT_W = 3;

  localparam logic [7:0] ADDR_BASE    = 8'd101;
  localparam logic [8:0] ADDR_LIMIT   = 9'(ADDR_BASE + NODE_COUNT);
  localparam logic [7:0] FRAME_START  = 8'd255;
  localparam logic [7:0] FRAME_END    = 8'd254;
  localparam logic [7:0] FRAME_OPTION = 8'd100;
  localparam logic [7:0] LED_ON       = 8'd128;
  localparam logic [7:0] LED_OFF      = 8'd0;

  localparam logic [NODE_IDX_W-1:0] LAST_NODE = NODE_IDX_W'(NODE_COUNT - 1);

  localparam logic [BYTE_CNT_W-1:0] BYTE_START  = 3'd0;
  localparam logic [BYTE_CNT_W-1:0] BYTE_ADDR   = 3'd1;
  localparam logic [BYTE_CNT_W-1:0] BYTE_LED0   = 3'd2;
  localparam logic [BYTE_CNT_W-1:0] BYTE_LED1   = 3'd3;
  localparam logic [BYTE_CNT_W-1:0] BYTE_LED2   = 3'd4;
  localparam logic [BYTE_CNT_W-1:0] BYTE_OPTION = 3'd5;
  localparam logic [BYTE_CNT_W-1:0] BYTE_END    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 8'd1;

  localparam logic [15:0] INTERVAL_RESET  = 16'd100;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd10;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] node_address;
    logic [7:0] sensor_reading;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_word_t;

  // One queued poll: the node address byte and whether its LEDs light.
  typedef struct packed {
    logic [7:0] node_addr;
    logic       led_on;
  } frame_cmd_t;

  function automatic logic [7:0] frame_byte(input logic [BYTE_CNT_W-1:0] pos,
                                            input frame_cmd_t cmd);
    logic [7:0] led;
    led = cmd.led_on ? LED_ON : LED_OFF;
    case (pos)
      BYTE_START:  frame_byte = FRAME_START;
      BYTE_ADDR:   frame_byte = cmd.node_addr;
      BYTE_LED0:   frame_byte = led;
      BYTE_LED1:   frame_byte = led;
      BYTE_LED2:   frame_byte = led;
      BYTE_OPTION: frame_byte = FRAME_OPTION;
      BYTE_END:    frame_byte = FRAME_END;
      default:     frame_byte = FRAME_END;
    endcase
  endfunction

endpackage

[hdl/snp_front.sv]
// Front end: takes words, keeps the node readings and the poll timer, queues poll frames.
module snp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  snp_pkg::in_word_t            in_word_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [snp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [snp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                         push_o,
  output snp_pkg::frame_cmd_t          push_cmd_o,
  input  logic                         queue_full_i
);

  logic [15:0] interval_q;
  logic [7:0]  threshold_q;
  logic [15:0] elapsed_q, elapsed_d;
  logic [snp_pkg::NODE_IDX_W-1:0] ptr_q, ptr_d;
  logic [7:0] base_q [snp_pkg::NODE_COUNT];
  logic [7:0] value_q [snp_pkg::NODE_COUNT];

  logic        accept;
  logic        is_tick;
  logic        fire;
  logic [15:0] elapsed_inc;
  logic [7:0]  rep_off;
  logic        rep_in_range;
  logic [snp_pkg::NODE_IDX_W-1:0] rep_idx;
  logic [snp_pkg::NODE_IDX_W-1:0] ptr_next;
  logic [7:0]  sel_value, sel_base, diff;

  assign in_stall_o  = queue_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign is_tick     = (in_word_i.kind == snp_pkg::KIND_TICK);

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign fire        = accept && is_tick && (elapsed_inc >= interval_q);
  assign ptr_next    = (ptr_q >= snp_pkg::LAST_NODE) ? '0 : ptr_q + 1'b1;

  assign rep_off      = in_word_i.node_address - snp_pkg::ADDR_BASE;
  assign rep_idx      = rep_off[snp_pkg::NODE_IDX_W-1:0];
  assign rep_in_range = (in_word_i.node_address >= snp_pkg::ADDR_BASE) &&
                        ({1'b0, in_word_i.node_address} < snp_pkg::ADDR_LIMIT);

  // The LED state is judged against the readings held when the frame is raised.
  assign sel_value = value_q[ptr_next];
  assign sel_base  = base_q[ptr_next];
  assign diff      = (sel_value >= sel_base) ? sel_value - sel_base : sel_base - sel_value;

  assign push_o               = fire;
  assign push_cmd_o.node_addr = snp_pkg::ADDR_BASE + 8'(ptr_next);
  assign push_cmd_o.led_on    = (diff > threshold_q);

  always_comb begin
    elapsed_d = elapsed_q;
    ptr_d     = ptr_q;
    if (accept && is_tick) begin
      if (fire) begin
        elapsed_d = '0;
        ptr_d     = ptr_next;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= snp_pkg::INTERVAL_RESET;
      threshold_q <= snp_pkg::THRESHOLD_RESET;
      elapsed_q   <= '0;
      ptr_q       <= snp_pkg::LAST_NODE;
      for (int i = 0; i < snp_pkg::NODE_COUNT; i++) begin
        base_q[i]  <= '0;
        value_q[i] <= '0;
      end
    end else begin
      elapsed_q <= elapsed_d;
      ptr_q     <= ptr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == snp_pkg::CFG_POLL_INTERVAL) begin
          interval_q <= cfg_data_i[15:0];
        end else if (cfg_index_i == snp_pkg::CFG_THRESHOLD) begin
          threshold_q <= cfg_data_i[7:0];
        end
      end
      if (accept && !is_tick && rep_in_range) begin
        value_q[rep_idx] <= in_word_i.sensor_reading;
        if (base_q[rep_idx] == 8'd0) begin
          base_q[rep_idx] <= in_word_i.sensor_reading;
        end
      end
    end
  end

endmodule

[hdl/snp_queue.sv]
// Two-entry queue of poll frame commands between the front end and the serializer.
module snp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  snp_pkg::frame_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output snp_pkg::frame_cmd_t head_o
);

  snp_pkg::frame_cmd_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/snp_back.sv]
// Serializer: turns each queued poll command into the seven frame bytes on the output.
module snp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  snp_pkg::frame_cmd_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output snp_pkg::out_word_t  out_word_o
);

  snp_pkg::frame_cmd_t cmd_q;
  logic                active_q, active_d;
  logic [snp_pkg::BYTE_CNT_W-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  snp_pkg::out_word_t  out_q, out_d;
  logic                advance;

  assign advance     = !out_valid_q || !out_stall_i;
  assign pop_o       = advance && !active_q && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    active_d    = active_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      if (active_q) begin
        out_valid_d       = 1'b1;
        out_d.tx_byte     = snp_pkg::frame_byte(cnt_q, cmd_q);
        out_d.last_byte   = (cnt_q == snp_pkg::BYTE_END);
        cnt_d             = cnt_q + 1'b1;
        active_d          = (cnt_q != snp_pkg::BYTE_END);
      end else if (!empty_i) begin
        // The start byte is registered in the same cycle the command is taken.
        out_valid_d       = 1'b1;
        out_d.tx_byte     = snp_pkg::frame_byte(snp_pkg::BYTE_START, head_i);
        out_d.last_byte   = 1'b0;
        cnt_d             = snp_pkg::BYTE_ADDR;
        active_d          = 1'b1;
      end else begin
        out_valid_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o) begin
      cmd_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/sensor_node_poller.sv]
// Top level of the sensor node poller: front end, command queue and frame serializer.
// First byte: a tick that fires a poll passes through the command queue registers and
// then the serializer output register. Throughput: one input word per cycle unless the
// command queue is full; a frame holds the serializer for its seven bytes, so the
// two-entry command queue stalls the input once polls outpace the output.
// Reset: asynchronous, active low; timer, node pointer, readings, baselines and the
// configuration registers take their reset values at once, with no clearing pass.
module sensor_node_poller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  snp_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output snp_pkg::out_word_t             out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [snp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [snp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic                push;
  snp_pkg::frame_cmd_t push_cmd;
  logic                queue_full;
  logic                queue_empty;
  logic                pop;
  snp_pkg::frame_cmd_t head;

  snp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .queue_full_i (queue_full)
  );

  snp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (pop),
    .empty_o    (queue_empty),
    .head_o     (head)
  );

  snp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (queue_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[hdl/snp_checker.sv]
// Port-level checker for the sensor node poller and its bind to the top level.
module snp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input snp_pkg::in_word_t              in_word_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input snp_pkg::out_word_t             out_word_o
);

  // A stalled output word must hold until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // A stalled input word is held by the sender until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("stalled input word changed");

  // The end flag only ever marks the frame end byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.last_byte |-> out_word_o.tx_byte == snp_pkg::FRAME_END)
    else $error("end flag on a byte other than the frame end");

  // After the end byte is taken, the next word shown opens a new frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.last_byte ##1 out_valid_o
    |-> out_word_o.tx_byte == snp_pkg::FRAME_START)
    else $error("frame does not begin with the start byte");

  // Once reset has been seen at an edge, no output word is shown while it is held.
  assert property (@(posedge clk_i) !rst_ni ##1 !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind sensor_node_poller snp_checker u_snp_checker (.*);
